// ----- sv/hab_pkg.sv -----
// Shared types and constants for the Higdon absorbing boundary block.
package hab_pkg;

    localparam int LINE_W    = 12;
    localparam int LINE_MAX  = 1 << LINE_W;
    localparam int VEL_W     = 14;
    localparam int RATIO_W   = 24;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = VEL_W + RATIO_W;
    localparam int DIV_W     = 40;
    localparam int Q_BITS    = 31;
    localparam int NUM_W     = 57;
    localparam int COEF_FRAC = 30;
    localparam int QUEUE_AW  = 2;
    localparam int QUEUE_D   = 1 << QUEUE_AW;

    localparam logic [NUM_W-1:0] NUM_FIVE = NUM_W'(5) << 54;
    localparam logic [32:0] TWO_THIRDS_Q30 = 33'd715827883;

    localparam logic [0:0] REG_RATIO_X = 1'b0;
    localparam logic [0:0] REG_RATIO_Z = 1'b1;

    typedef struct packed {
        logic [LINE_W-1:0]        line;
        logic                     start;
        logic signed [DATA_W-1:0] p_here;
        logic signed [DATA_W-1:0] p_inner;
        logic                     corner;
        logic signed [DATA_W-1:0] partner;
    } meta_t;

    typedef struct packed {
        meta_t              meta;
        logic signed [31:0] coef_a;
        logic signed [32:0] coef_b;
    } item_t;

endpackage

// ----- sv/hab_front.sv -----
// Front end: Courant product, pipelined restoring divider and coefficient stage.
module hab_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [hab_pkg::RATIO_W-1:0]         ratio_x,
    input  logic [hab_pkg::RATIO_W-1:0]         ratio_z,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                axis,
    input  logic [hab_pkg::VEL_W-1:0]           velocity,
    input  hab_pkg::meta_t                      in_meta,
    output logic                                o_valid,
    output hab_pkg::item_t                      o_item,
    input  logic                                o_ready
);

    localparam int NS = hab_pkg::Q_BITS;

    logic en;

    logic                        s0_valid_reg;
    hab_pkg::meta_t              s0_meta_reg;
    logic [hab_pkg::PROD_W-1:0]  s0_prod_reg;

    // element 0 is the setup stage, 1..NS the quotient stages
    logic                        dv_valid_reg [NS+1];
    hab_pkg::meta_t              dv_meta_reg  [NS+1];
    logic [hab_pkg::DIV_W-1:0]   dv_d_reg     [NS+1];
    logic [hab_pkg::DIV_W-1:0]   dv_rem_reg   [NS+1];
    logic [NS-1:0]               dv_low_reg   [NS+1];
    logic [NS-1:0]               dv_q_reg     [NS+1];

    logic                        o_valid_reg;
    hab_pkg::item_t              o_item_reg;

    logic [hab_pkg::RATIO_W-1:0] ratio_sel;
    logic [hab_pkg::PROD_W:0]    s_val;
    logic [hab_pkg::DIV_W-1:0]   d_val;
    logic [hab_pkg::NUM_W-1:0]   m_val;

    assign en       = !o_valid_reg || o_ready;
    assign in_ready = en;
    assign o_valid  = o_valid_reg;
    assign o_item   = o_item_reg;

    assign ratio_sel = axis ? ratio_z : ratio_x;
    assign s_val = {1'b0, s0_prod_reg} + (hab_pkg::PROD_W+1)'(1 << hab_pkg::RATIO_W);
    assign d_val = {1'b0, s_val} + {s_val, 1'b0};
    assign m_val = hab_pkg::NUM_FIVE + hab_pkg::NUM_W'(d_val[hab_pkg::DIV_W-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            o_valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            dv_valid_reg[0] <= s0_valid_reg;
            o_valid_reg     <= dv_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_meta_reg    <= in_meta;
            s0_prod_reg    <= velocity * ratio_sel;
            dv_meta_reg[0] <= s0_meta_reg;
            dv_d_reg[0]    <= d_val;
            dv_rem_reg[0]  <= hab_pkg::DIV_W'(m_val[hab_pkg::NUM_W-1:NS]);
            dv_low_reg[0]  <= m_val[NS-1:0];
            dv_q_reg[0]    <= '0;
            o_item_reg.meta   <= dv_meta_reg[NS];
            o_item_reg.coef_a <= 32'sd1073741824 - $signed({1'b0, dv_q_reg[NS]});
            o_item_reg.coef_b <= $signed({2'b00, dv_q_reg[NS]} - hab_pkg::TWO_THIRDS_Q30);
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_div
        logic [hab_pkg::DIV_W:0] trial;
        logic [hab_pkg::DIV_W:0] diff;
        logic                    ge;

        assign trial = {dv_rem_reg[k-1], dv_low_reg[k-1][NS-1]};
        assign diff  = trial - {1'b0, dv_d_reg[k-1]};
        assign ge    = trial >= {1'b0, dv_d_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k] <= 1'b0;
            else if (en)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_meta_reg[k] <= dv_meta_reg[k-1];
                dv_d_reg[k]    <= dv_d_reg[k-1];
                dv_rem_reg[k]  <= ge ? diff[hab_pkg::DIV_W-1:0] : trial[hab_pkg::DIV_W-1:0];
                dv_low_reg[k]  <= {dv_low_reg[k-1][NS-2:0], 1'b0};
                dv_q_reg[k]    <= {dv_q_reg[k-1][NS-2:0], ge};
            end
        end
    end

endmodule

// ----- sv/hab_queue.sv -----
// Short transaction queue between the front and back ends.
module hab_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hab_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output hab_pkg::item_t head_item
);

    hab_pkg::item_t                 mem [hab_pkg::QUEUE_D];
    logic [hab_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [hab_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [hab_pkg::QUEUE_AW:0]     count_reg;
    logic [hab_pkg::QUEUE_AW:0]     count_next;

    assign full       = count_reg == (hab_pkg::QUEUE_AW+1)'(hab_pkg::QUEUE_D);
    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- sv/hab_back.sv -----
// Back end: per-line store, same-line interlock, multiply-accumulate and output register.
module hab_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  hab_pkg::item_t                   head_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [hab_pkg::DATA_W-1:0] boundary_value,
    output logic signed [hab_pkg::DATA_W-1:0] cell_value
);

    logic signed [hab_pkg::DATA_W-1:0] mem [hab_pkg::LINE_MAX];

    logic en;
    logic hazard;

    logic                              b1_valid_reg;
    hab_pkg::item_t                    b1_item_reg;
    logic signed [hab_pkg::DATA_W-1:0] b1_rd_reg;

    logic                              b2_valid_reg;
    logic [hab_pkg::LINE_W-1:0]        b2_line_reg;
    logic                              b2_corner_reg;
    logic signed [hab_pkg::DATA_W-1:0] b2_partner_reg;
    logic signed [63:0]                b2_pa_reg;
    logic signed [64:0]                b2_pb_reg;
    logic signed [63:0]                b2_pc_reg;

    logic                              b3_valid_reg;
    logic [hab_pkg::LINE_W-1:0]        b3_line_reg;
    logic                              b3_corner_reg;
    logic signed [hab_pkg::DATA_W-1:0] b3_partner_reg;
    logic signed [65:0]                b3_acc_reg;

    logic                              out_valid_reg;
    logic signed [hab_pkg::DATA_W-1:0] bnd_reg;
    logic signed [hab_pkg::DATA_W-1:0] cell_reg;

    logic signed [hab_pkg::DATA_W-1:0] prev;
    logic signed [65:0]                rounded;
    logic signed [35:0]                shifted;
    logic signed [hab_pkg::DATA_W-1:0] bnd_next;
    logic signed [32:0]                pair_sum;

    assign en = !out_valid_reg || out_ready;

    // hold the head, unless it starts its line, while an older transaction of the same line is still in flight
    assign hazard = !head_item.meta.start &&
                    ((b1_valid_reg && b1_item_reg.meta.line == head_item.meta.line) ||
                     (b2_valid_reg && b2_line_reg == head_item.meta.line) ||
                     (b3_valid_reg && b3_line_reg == head_item.meta.line));
    assign pop = en && head_valid && !hazard;

    assign prev = b1_item_reg.meta.start ? b1_item_reg.meta.p_inner : b1_rd_reg;

    assign rounded = b3_acc_reg + 66'sd536870912;
    assign shifted = 36'(rounded >>> hab_pkg::COEF_FRAC);
    always_comb
    begin
        if (shifted > 36'sd2147483647)
            bnd_next = 32'sh7FFFFFFF;
        else if (shifted < -36'sd2147483648)
            bnd_next = 32'sh80000000;
        else
            bnd_next = shifted[31:0];
    end
    assign pair_sum = {bnd_next[31], bnd_next} + {b3_partner_reg[31], b3_partner_reg};

    assign out_valid      = out_valid_reg;
    assign boundary_value = bnd_reg;
    assign cell_value     = cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b1_rd_reg <= mem[head_item.meta.line];
        if (en && b3_valid_reg)
            mem[b3_line_reg] <= bnd_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_item_reg    <= head_item;
            b2_line_reg    <= b1_item_reg.meta.line;
            b2_corner_reg  <= b1_item_reg.meta.corner;
            b2_partner_reg <= b1_item_reg.meta.partner;
            b2_pa_reg      <= b1_item_reg.coef_a * prev;
            b2_pb_reg      <= b1_item_reg.coef_b * b1_item_reg.meta.p_here;
            b2_pc_reg      <= $signed({1'b0, hab_pkg::TWO_THIRDS_Q30[30:0]})
                              * b1_item_reg.meta.p_inner;
            b3_line_reg    <= b2_line_reg;
            b3_corner_reg  <= b2_corner_reg;
            b3_partner_reg <= b2_partner_reg;
            b3_acc_reg     <= 66'(b2_pa_reg) + 66'(b2_pb_reg) + 66'(b2_pc_reg);
            bnd_reg        <= bnd_next;
            cell_reg       <= b3_corner_reg ? pair_sum[32:1] : bnd_next;
        end
    end

endmodule

// ----- sv/higdon_absorbing_boundary.sv -----
// Top level of the first-order Higdon absorbing boundary block.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  in        input      in_valid / in_ready        line_index axis line_start p_here
//                                                  p_inner velocity corner partner_value
//  out       output     out_valid / out_ready      boundary_value cell_value
//  cfg       input      cfg_write (no wait)        cfg_index cfg_data
//
//  One transaction per cycle sustained while no stall or line interlock holds the flow;
//  the weight is formed by the 31-stage restoring divider.
//  A transaction that reuses a line stored by one of the three transactions
//  ahead of it waits in the queue until that line's value has been written.
//  Reset clears the ratio registers and pipeline and queue control; the per-line
//  store is not cleared.
//  Either side may stall independently; the queue and output register absorb it.
module higdon_absorbing_boundary (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [0:0]                          cfg_index,
    input  logic [hab_pkg::RATIO_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hab_pkg::LINE_W-1:0]          line_index,
    input  logic                                axis,
    input  logic                                line_start,
    input  logic signed [hab_pkg::DATA_W-1:0]   p_here,
    input  logic signed [hab_pkg::DATA_W-1:0]   p_inner,
    input  logic [hab_pkg::VEL_W-1:0]           velocity,
    input  logic                                corner,
    input  logic signed [hab_pkg::DATA_W-1:0]   partner_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hab_pkg::DATA_W-1:0]   boundary_value,
    output logic signed [hab_pkg::DATA_W-1:0]   cell_value
);

    logic [hab_pkg::RATIO_W-1:0] ratio_x_reg;
    logic [hab_pkg::RATIO_W-1:0] ratio_z_reg;

    hab_pkg::meta_t in_meta;
    logic           fr_valid;
    hab_pkg::item_t fr_item;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    hab_pkg::item_t q_head_item;

    // configuration writes: unknown indexes cannot occur with a one-bit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_x_reg <= '0;
            ratio_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hab_pkg::REG_RATIO_X: ratio_x_reg <= cfg_data;
                hab_pkg::REG_RATIO_Z: ratio_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // bundle the fields that ride along the divider unchanged
    always_comb
    begin
        in_meta.line    = line_index;
        in_meta.start   = line_start;
        in_meta.p_here  = p_here;
        in_meta.p_inner = p_inner;
        in_meta.corner  = corner;
        in_meta.partner = partner_value;
    end

    // front: Courant number and weight t = 5/(3(1+r)) in Q1.30
    hab_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ratio_x  (ratio_x_reg),
        .ratio_z  (ratio_z_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .axis     (axis),
        .velocity (velocity),
        .in_meta  (in_meta),
        .o_valid  (fr_valid),
        .o_item   (fr_item),
        .o_ready  (!q_full)
    );

    // decouple the front from the line interlock in the back
    hab_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_valid && !q_full),
        .push_item  (fr_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // back: read the line's last value, weigh, round, saturate, store
    hab_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_item      (q_head_item),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .boundary_value (boundary_value),
        .cell_value     (cell_value)
    );

endmodule

// ----- dv/tb.sv -----
// Testbench for the Higdon absorbing boundary block: directed and random transactions.
`timescale 1ns / 100ps

module tb;

    localparam longint unsigned RATIO_UNIT = 64'd16777216;  // 1.0 in Q0.24
    localparam longint unsigned WEIGHT_NUM = 64'd5 << 54;   // 5/3 numerator, Q.30 scaled
    localparam longint TWO_THIRDS = 64'sd715827883;         // 2/3 in Q.30
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;  // margin beyond the pipeline depth

    typedef struct {
        logic [hab_pkg::LINE_W-1:0]        line_index;
        logic                              axis;
        logic                              line_start;
        logic signed [hab_pkg::DATA_W-1:0] p_here;
        logic signed [hab_pkg::DATA_W-1:0] p_inner;
        logic [hab_pkg::VEL_W-1:0]         velocity;
        logic                              corner;
        logic signed [hab_pkg::DATA_W-1:0] partner_value;
    } grid_point_t;

    typedef struct {
        logic signed [hab_pkg::DATA_W-1:0] boundary_value;
        logic signed [hab_pkg::DATA_W-1:0] cell_value;
    } cell_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [0:0] cfg_index;
    logic [hab_pkg::RATIO_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [hab_pkg::LINE_W-1:0] line_index;
    logic axis;
    logic line_start;
    logic signed [hab_pkg::DATA_W-1:0] p_here;
    logic signed [hab_pkg::DATA_W-1:0] p_inner;
    logic [hab_pkg::VEL_W-1:0] velocity;
    logic corner;
    logic signed [hab_pkg::DATA_W-1:0] partner_value;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [hab_pkg::DATA_W-1:0] boundary_value;
    logic signed [hab_pkg::DATA_W-1:0] cell_value;

    // Predictor state: shadow registers and the per-line boundary store
    logic [hab_pkg::RATIO_W-1:0] ratio_x_shadow;
    logic [hab_pkg::RATIO_W-1:0] ratio_z_shadow;
    logic signed [hab_pkg::DATA_W-1:0] line_store [hab_pkg::LINE_MAX];
    bit line_written [hab_pkg::LINE_MAX];

    cell_result_t pending_cells[$];
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;

    higdon_absorbing_boundary dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .line_index(line_index), .axis(axis), .line_start(line_start),
        .p_here(p_here), .p_inner(p_inner), .velocity(velocity),
        .corner(corner), .partner_value(partner_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .boundary_value(boundary_value), .cell_value(cell_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Randomly back-pressure the output at the current phase's rate
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Compute the boundary extrapolation and advance the line store
    function automatic cell_result_t extrapolate_point(grid_point_t pt);
        longint unsigned ratio;
        longint unsigned denom;
        longint weight;
        longint prev;
        longint acc;
        longint bnd;
        cell_result_t res;
        ratio = pt.axis ? longint'(ratio_z_shadow) : longint'(ratio_x_shadow);
        denom = 3 * (RATIO_UNIT + longint'(pt.velocity) * ratio);
        weight = longint'((WEIGHT_NUM + denom / 2) / denom);
        prev = pt.line_start ? longint'(pt.p_inner) : longint'(line_store[pt.line_index]);
        acc = ((64'sd1 <<< hab_pkg::COEF_FRAC) - weight) * prev
            + (weight - TWO_THIRDS) * longint'(pt.p_here)
            + TWO_THIRDS * longint'(pt.p_inner);
        bnd = (acc + (64'sd1 <<< (hab_pkg::COEF_FRAC - 1))) >>> hab_pkg::COEF_FRAC;
        if (bnd > SAT_HI)
            bnd = SAT_HI;
        if (bnd < SAT_LO)
            bnd = SAT_LO;
        res.boundary_value = bnd[31:0];
        if (pt.corner)
            res.cell_value = 32'((bnd + longint'(pt.partner_value)) >>> 1);
        else
            res.cell_value = bnd[31:0];
        line_store[pt.line_index] = bnd[31:0];
        line_written[pt.line_index] = 1'b1;
        return res;
    endfunction

    // Compare every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        cell_result_t exp_cell;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result bnd=%0d cell=%0d", boundary_value, cell_value);
            end
            else
            begin
                exp_cell = pending_cells.pop_front();
                if (exp_cell.boundary_value !== boundary_value
                    || exp_cell.cell_value !== cell_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: bnd exp %0d got %0d, cell exp %0d got %0d",
                                 exp_cell.boundary_value, boundary_value,
                                 exp_cell.cell_value, cell_value);
                end
            end
        end
    end

    // Drive one grid point, hold it until accepted, then predict
    task automatic send_point(grid_point_t pt);
        // never read a line whose value was never stored
        if (!line_written[pt.line_index])
            pt.line_start = 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        line_index <= pt.line_index;
        axis <= pt.axis;
        line_start <= pt.line_start;
        p_here <= pt.p_here;
        p_inner <= pt.p_inner;
        velocity <= pt.velocity;
        corner <= pt.corner;
        partner_value <= pt.partner_value;
        do
            @(posedge clk);
        while (!in_ready);
        pending_cells.push_back(extrapolate_point(pt));
    endtask

    // Drop valid and wait until every prediction has been matched
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ratio(logic [0:0] idx, logic [hab_pkg::RATIO_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == hab_pkg::REG_RATIO_X)
            ratio_x_shadow = value;
        else
            ratio_z_shadow = value;
    endtask

    function automatic logic signed [hab_pkg::DATA_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return hab_pkg::DATA_W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return hab_pkg::DATA_W'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic grid_point_t random_point(logic [hab_pkg::LINE_W-1:0] line, logic first);
        grid_point_t pt;
        pt.line_index = line;
        pt.axis = 1'($urandom_range(0, 1));
        pt.line_start = first;
        pt.p_here = random_sample();
        pt.p_inner = random_sample();
        pt.velocity = ($urandom_range(0, 3) == 0) ? hab_pkg::VEL_W'($urandom_range(0, 16383))
                                                   : hab_pkg::VEL_W'($urandom_range(1000, 6000));
        pt.corner = ($urandom_range(0, 3) == 0);
        pt.partner_value = random_sample();
        return pt;
    endfunction

    // Field extremes, saturation, corners, zero velocity and zero ratio
    task automatic test_directed();
        grid_point_t pt;
        write_ratio(hab_pkg::REG_RATIO_X, 24'd0);
        write_ratio(hab_pkg::REG_RATIO_Z, 24'hffffff);
        pt = random_point(12'd0, 1'b1);
        pt.velocity = '0;
        send_point(pt);
        pt = random_point(12'd4095, 1'b1);
        pt.velocity = 14'h3fff;
        pt.axis = 1'b1;
        send_point(pt);
        // push hard toward the positive and negative rails
        for (int k = 0; k < 4; k++)
        begin
            pt = random_point(12'd4095, k == 0);
            pt.axis = 1'b1;
            pt.velocity = 14'h3fff;
            pt.p_here = k[0] ? 32'sh7fffffff : 32'sh80000000;
            pt.p_inner = k[0] ? 32'sh80000000 : 32'sh7fffffff;
            pt.corner = k[1];
            pt.partner_value = k[0] ? 32'sh80000000 : 32'sh7fffffff;
            send_point(pt);
        end
        for (int k = 0; k < 8; k++)
        begin
            pt = random_point(12'hAAA ^ {12{k[0]}}, k < 2);
            pt.axis = k[1];
            pt.corner = k[2];
            pt.velocity = k[0] ? 14'h3fff : 14'd0;
            pt.partner_value = k[2] ? 32'sh80000000 : 32'sh7fffffff;
            send_point(pt);
        end
        drain();
    endtask

    // Walk well-formed lines: each starts at the inner edge, then continues
    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        logic [hab_pkg::LINE_W-1:0] lines [8];
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        foreach (lines[k])
            lines[k] = hab_pkg::LINE_W'($urandom_range(0, hab_pkg::LINE_MAX - 1));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                lines[pick] = hab_pkg::LINE_W'($urandom_range(0, hab_pkg::LINE_MAX - 1));
            send_point(random_point(lines[pick], $urandom_range(0, 19) == 0));
            // one deliberate hold-off mid-phase
            if (n == count / 2)
                drain();
        end
        drain();
    endtask

    // Step through register settings between drained phases
    task automatic test_ratio_settings();
        logic [hab_pkg::RATIO_W-1:0] settings [4] = '{24'd0, 24'hffffff, 24'd2097, 24'd1677};
        foreach (settings[k])
        begin
            write_ratio(hab_pkg::REG_RATIO_X, settings[k]);
            write_ratio(hab_pkg::REG_RATIO_Z, settings[3 - k]);
            test_random_phase(0, 0, 40);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        line_index = '0;
        axis = 1'b0;
        line_start = 1'b0;
        p_here = '0;
        p_inner = '0;
        velocity = '0;
        corner = 1'b0;
        partner_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ratio_x_shadow = '0;
        ratio_z_shadow = '0;
        foreach (line_written[k])
            line_written[k] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ratio_settings();
        write_ratio(hab_pkg::REG_RATIO_X, 24'd1342);
        write_ratio(hab_pkg::REG_RATIO_Z, 24'd2516);
        test_random_phase(0, 0, 350);
        test_random_phase(55, 0, 350);
        test_random_phase(0, 55, 350);
        write_ratio(hab_pkg::REG_RATIO_X, hab_pkg::RATIO_W'($urandom_range(0, 24'hffffff)));
        write_ratio(hab_pkg::REG_RATIO_Z, hab_pkg::RATIO_W'($urandom_range(0, 4000)));
        test_random_phase(11, 11, 350);

        if (mismatches == 0 && pending_cells.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hab_pkg.sv
sv/hab_front.sv
sv/hab_queue.sv
sv/hab_back.sv
sv/higdon_absorbing_boundary.sv
dv/tb.sv
